[hw/rtl/sae_pkg.sv]
// shared types and constants of the sorted adjacency edge store
package sae_pkg;

    localparam int VERTICES_DEF   = 16;
    localparam int MAX_DEGREE_DEF = 16;

    localparam int VID_W  = 4;
    localparam int WT_W   = 64;
    localparam int POS_W  = 4;
    localparam int LCNT_W = 5;
    localparam int VC_W   = 5;
    localparam logic [VC_W-1:0] VC_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_BEYOND   = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH,
        S_CMP,
        S_FULLCHK,
        S_SHIFT,
        S_PUT,
        S_READ_CAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              op;
        logic              sel;
        logic [VID_W-1:0]  src;
        logic [VID_W-1:0]  dst;
        logic [WT_W-1:0]   wt;
        logic [POS_W-1:0]  idx;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  opos;
        logic [POS_W-1:0]  ipos;
        logic [VID_W-1:0]  nbr;
        logic [WT_W-1:0]   wt;
        logic [LCNT_W-1:0] lcnt;
    } t_res;

endpackage

[hw/rtl/sorted_adjacency_edge_insert_core.sv]
// Sorted adjacency edge store: per vertex an outgoing and an incoming edge list kept sorted by
// neighbor id in two list memories. One word is worked on at a time. A read word fetches the
// entry at the given index of one list. An add runs a binary search over the outgoing and then
// the incoming list, and in each list shifts the entries from the insert place up by one and
// writes the entry, with no shift where the neighbor is already present. The list memories
// take one read and one write a cycle: each probe needs a read and a compare, each moved
// entry one read and one write. The next word is taken while a finished result still waits
// in the output register.
module sorted_adjacency_edge_insert_core #(
    parameter int VERTICES   = sae_pkg::VERTICES_DEF,
    parameter int MAX_DEGREE = sae_pkg::MAX_DEGREE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,    // vertex_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_vertex[3:0], dst_vertex[7:4], weight[71:8], entry_index[75:72], zero pad
    input  logic [79:0] s_axis_tdata,
    // opcode[0], list_select[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_position[3:0], in_position[7:4], entry_neighbor[11:8], entry_weight[75:12],
    // list_count[80:76], zero pad
    output logic [87:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser
);
    import sae_pkg::*;

    logic [VC_W-1:0] r_vcount;
    t_item           item;
    t_res            res, r_out;
    logic            res_valid, res_ready;
    logic            r_ovalid;

    assign item.op  = s_axis_tuser[0];
    assign item.sel = s_axis_tuser[1];
    assign item.src = s_axis_tdata[3:0];
    assign item.dst = s_axis_tdata[7:4];
    assign item.wt  = s_axis_tdata[71:8];
    assign item.idx = s_axis_tdata[75:72];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VC_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    sae_seq #(.VERTICES(VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vcount    (r_vcount),
        .i_item      (item),
        .i_item_valid(s_axis_tvalid),
        .o_item_ready(s_axis_tready),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready)
    );

    // output register frees the sequencer as soon as a result is parked
    assign res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {7'd0, r_out.lcnt, r_out.wt, r_out.nbr, r_out.ipos, r_out.opos};

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after an accept");

    a_load_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(res_valid))
        else $error("output word appeared without a sequencer result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_RANGE))
        else $error("status code out of range");
`endif

endmodule

[hw/rtl/sae_list_mem.sv]
// single-port-write list entry memory, neighbor id and weight, registered read
module sae_list_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [sae_pkg::VID_W-1:0] i_wnb,
    input  logic [sae_pkg::WT_W-1:0]  i_wwt,
    input  logic [AW-1:0]            i_raddr,
    output logic [sae_pkg::VID_W-1:0] o_rnb,
    output logic [sae_pkg::WT_W-1:0]  o_rwt
);
    import sae_pkg::*;

    logic [VID_W+WT_W-1:0] r_mem [DEPTH];
    logic [VID_W+WT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wnb, i_wwt};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rnb = r_rdata[VID_W+WT_W-1:WT_W];
    assign o_rwt = r_rdata[WT_W-1:0];

endmodule

[hw/rtl/sae_seq.sv]
// sequencer: binary search, shift-up insert and entry read over the list memories
module sae_seq #(
    parameter int VERTICES   = 16,
    parameter int MAX_DEGREE = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [sae_pkg::VC_W-1:0] i_vcount,
    input  sae_pkg::t_item           i_item,
    input  logic                     i_item_valid,
    output logic                     o_item_ready,
    output sae_pkg::t_res            o_res,
    output logic                     o_res_valid,
    input  logic                     i_res_ready
);
    import sae_pkg::*;

    localparam int VW    = $clog2(VERTICES);
    localparam int CW    = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH = VERTICES * MAX_DEGREE;
    localparam int AW    = $clog2(DEPTH);

    t_state          r_state, n_state;
    t_item           r_it, n_it;
    t_res            r_res, n_res;
    logic            r_list, n_list;
    logic [CW-1:0]   r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_j, n_j;
    logic            r_shv, n_shv;
    logic            r_fo, n_fo, r_fi, n_fi;
    logic [CW-1:0]   r_po, n_po, r_pi, n_pi;
    logic [CW-1:0]   r_ocnt [VERTICES];
    logic [CW-1:0]   r_icnt [VERTICES];

    logic [CW-1:0]   ocnt_cur, icnt_cur, rcnt, mid;
    logic [VID_W-1:0] key, lvert;
    logic            lsel, lfnd;
    logic [CW-1:0]   lpos;
    logic            fin, fin_fnd;
    logic [CW-1:0]   fin_pos;
    logic            we, inc;
    logic [AW-1:0]   ra, wa;
    logic [VID_W-1:0] wnb;
    logic [WT_W-1:0] wwt;
    logic [VID_W-1:0] o_nb, i_nb, rnb;
    logic [WT_W-1:0] o_wt, i_wt, rwt;

    function automatic logic [AW-1:0] f_addr(input logic [VID_W-1:0] v,
                                             input logic [CW-1:0] p);
        return AW'(int'(v) * MAX_DEGREE + int'(p));
    endfunction

    function automatic logic f_vok(input logic [VID_W-1:0] v,
                                   input logic [VC_W-1:0] vc);
        return (VC_W'(v) < vc) && (int'(v) < VERTICES);
    endfunction

    sae_list_mem #(.DEPTH(DEPTH), .AW(AW)) u_out_mem (
        .i_clk(i_clk), .i_we(we && !lsel), .i_waddr(wa), .i_wnb(wnb), .i_wwt(wwt),
        .i_raddr(ra), .o_rnb(o_nb), .o_rwt(o_wt)
    );

    sae_list_mem #(.DEPTH(DEPTH), .AW(AW)) u_in_mem (
        .i_clk(i_clk), .i_we(we && lsel), .i_waddr(wa), .i_wnb(wnb), .i_wwt(wwt),
        .i_raddr(ra), .o_rnb(i_nb), .o_rwt(i_wt)
    );

    assign ocnt_cur = r_ocnt[VW'(r_it.src)];
    assign icnt_cur = r_icnt[VW'(r_it.op ? r_it.src : r_it.dst)];
    assign lsel     = r_it.op ? r_it.sel : r_list;
    assign key      = r_list ? r_it.src : r_it.dst;
    assign lvert    = r_it.op ? r_it.src : (r_list ? r_it.dst : r_it.src);
    assign lfnd     = r_list ? r_fi : r_fo;
    assign lpos     = r_list ? r_pi : r_po;
    assign rnb      = lsel ? i_nb : o_nb;
    assign rwt      = lsel ? i_wt : o_wt;
    assign rcnt     = r_it.sel ? icnt_cur : ocnt_cur;
    assign mid      = r_lo + CW'((r_hi - r_lo) >> 1);

    always_comb begin
        n_state = r_state;
        n_it    = r_it;
        n_res   = r_res;
        n_list  = r_list;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_j     = r_j;
        n_shv   = r_shv;
        n_fo    = r_fo;
        n_fi    = r_fi;
        n_po    = r_po;
        n_pi    = r_pi;
        fin     = 1'b0;
        fin_fnd = 1'b0;
        fin_pos = r_lo;
        we      = 1'b0;
        inc     = 1'b0;
        ra      = '0;
        wa      = '0;
        wnb     = '0;
        wwt     = '0;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_it    = i_item;
                    n_res   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_it.op) begin
                    if (!f_vok(r_it.src, i_vcount)) begin
                        n_res.status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_res.lcnt = LCNT_W'(rcnt);
                        if (int'(r_it.idx) >= int'(rcnt)) begin
                            n_res.status = ST_BEYOND;
                            n_state      = S_DONE;
                        end else begin
                            ra      = f_addr(r_it.src, CW'(r_it.idx));
                            n_state = S_READ_CAP;
                        end
                    end
                end else if (!f_vok(r_it.src, i_vcount) || !f_vok(r_it.dst, i_vcount)) begin
                    n_res.status = ST_RANGE;
                    n_state      = S_DONE;
                end else begin
                    n_list  = 1'b0;
                    n_lo    = '0;
                    n_hi    = ocnt_cur;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    ra      = f_addr(lvert, mid);
                    n_mid   = mid;
                    n_state = S_CMP;
                end else begin
                    fin = 1'b1;
                end
            end
            S_CMP: begin
                if (rnb == key) begin
                    fin     = 1'b1;
                    fin_fnd = 1'b1;
                    fin_pos = r_mid;
                end else if (rnb < key) begin
                    n_lo    = r_mid + 1'b1;
                    n_state = S_SRCH;
                end else begin
                    n_hi    = r_mid;
                    n_state = S_SRCH;
                end
            end
            S_FULLCHK: begin
                if ((!r_fo && int'(ocnt_cur) >= MAX_DEGREE) ||
                    (!r_fi && int'(icnt_cur) >= MAX_DEGREE)) begin
                    n_res.status = ST_FULL;
                    n_res.lcnt   = LCNT_W'(ocnt_cur);
                    n_state      = S_DONE;
                end else begin
                    n_list  = 1'b0;
                    n_j     = r_fo ? r_po : ocnt_cur;
                    n_shv   = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle one place up
                if (r_shv) begin
                    we  = 1'b1;
                    wa  = f_addr(lvert, CW'(r_j + 1'b1));
                    wnb = rnb;
                    wwt = rwt;
                end
                if (r_j > lpos) begin
                    ra    = f_addr(lvert, CW'(r_j - 1'b1));
                    n_j   = r_j - 1'b1;
                    n_shv = 1'b1;
                end else begin
                    n_shv   = 1'b0;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                we  = 1'b1;
                wa  = f_addr(lvert, lpos);
                wnb = key;
                wwt = r_it.wt;
                inc = !lfnd;
                if (!r_list) begin
                    n_list  = 1'b1;
                    n_j     = r_fi ? r_pi : icnt_cur;
                    n_shv   = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    n_res.status = r_fo ? ST_UPDATED : ST_INSERTED;
                    n_res.opos   = POS_W'(r_po);
                    n_res.ipos   = POS_W'(r_pi);
                    n_res.lcnt   = LCNT_W'(ocnt_cur);
                    n_state      = S_DONE;
                end
            end
            S_READ_CAP: begin
                n_res.nbr = rnb;
                n_res.wt  = rwt;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // search of one list finished
        if (fin) begin
            if (!r_list) begin
                n_fo    = fin_fnd;
                n_po    = fin_pos;
                n_list  = 1'b1;
                n_lo    = '0;
                n_hi    = icnt_cur;
                n_state = S_SRCH;
            end else begin
                n_fi    = fin_fnd;
                n_pi    = fin_pos;
                n_state = S_FULLCHK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it   <= n_it;
        r_res  <= n_res;
        r_list <= n_list;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_j    <= n_j;
        r_shv  <= n_shv;
        r_fo   <= n_fo;
        r_fi   <= n_fi;
        r_po   <= n_po;
        r_pi   <= n_pi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VERTICES; k++) begin
                r_ocnt[k] <= '0;
                r_icnt[k] <= '0;
            end
        end else if (inc) begin
            if (!r_list) begin
                r_ocnt[VW'(r_it.src)] <= r_ocnt[VW'(r_it.src)] + 1'b1;
            end else begin
                r_icnt[VW'(r_it.dst)] <= r_icnt[VW'(r_it.dst)] + 1'b1;
            end
        end
    end

    assign o_res = r_res;

endmodule
